FILE: hw/rtl/ccpc_pkg.sv
// ----------------------------------------------------------------------------
// Colour class pixel counter package
// Shared widths, register indexes, mode flag positions, count records and
// saturating arithmetic for the colour class pixel counter.
// ----------------------------------------------------------------------------
package ccpc_pkg;

	localparam int CNT_W = 25;
	localparam int CFG_W = 13;
	localparam int CFG_IDX_W = 3;
	localparam int PIX_W = 8;
	localparam int POS_W = 12;
	localparam int SEL_W = 4;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	localparam logic [PIX_W-1:0] PIX_FULL = 8'd255;
	localparam logic [PIX_W-1:0] PIX_ZERO = 8'd0;
	localparam logic [PIX_W-1:0] RED_LIMIT = 8'd100;
	localparam logic [PIX_W-1:0] WHITE_LIMIT = 8'd125;

	localparam logic [CFG_IDX_W-1:0] REG_MODE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TOP = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BOTTOM = 3'd4;

	localparam int MF_USE = 0;
	localparam int MF_AUTO = 1;
	localparam int MF_SEL_LO = 2;
	localparam int MF_MASK = 6;
	localparam int MF_WIN = 7;
	localparam int MF_WBLUE = 8;
	localparam int MF_WGREEN = 9;
	localparam int MF_WRED = 10;
	localparam int MF_WWHITE = 11;
	localparam int MF_WBLACK = 12;

	localparam logic [SEL_W-1:0] SEL_RED = 4'b0001;
	localparam logic [SEL_W-1:0] SEL_GREEN = 4'b0010;
	localparam logic [SEL_W-1:0] SEL_BLUE = 4'b0100;
	localparam logic [SEL_W-1:0] SEL_GRAY = 4'b1000;

	typedef struct packed {
		logic [CNT_W-1:0] red;
		logic [CNT_W-1:0] green;
		logic [CNT_W-1:0] blue;
		logic [CNT_W-1:0] gray;
	} class_cnt_t;

	typedef struct packed {
		logic [CNT_W-1:0] blue;
		logic [CNT_W-1:0] green;
		logic [CNT_W-1:0] red;
		logic [CNT_W-1:0] white;
		logic [CNT_W-1:0] black;
	} window_cnt_t;

	typedef struct packed {
		class_cnt_t  cls;
		window_cnt_t win;
	} snapshot_t;

	typedef struct packed {
		logic [SEL_W-1:0] sel;
		logic [CNT_W-1:0] total;
		class_cnt_t       cls;
		logic [CNT_W-1:0] win_total;
		window_cnt_t      win;
	} report_t;

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
			input logic [CNT_W-1:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
	endfunction

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] a,
			input logic en);
		return (en && (a != CNT_MAX)) ? a + 1'b1 : a;
	endfunction

endpackage

FILE: hw/rtl/color_class_pixel_counter.sv
// ----------------------------------------------------------------------------
// Colour class pixel counter
// Counts colour classes and window classes over a colour-coded frame and
// reports the picked classes and totals on the last pixel.
// ----------------------------------------------------------------------------
// One pixel transfer is taken every cycle; each pixel is registered, sorted
// and added to the counters in the next cycle. The last pixel of a frame
// hands its final counts to a five-register report pipeline, and the
// counters are clear for the next frame at once. Input stalls only while
// a last pixel waits for space in a full report pipeline. No clearing
// pass follows reset.
module color_class_pixel_counter #(
	parameter int MAX_SIDE = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ccpc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ccpc_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// blue, green, red, mask_value, col, row
	input  logic [55:0]                   s_tdata,
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// selected_classes, total_count, red_count, green_count, blue_count,
	// gray_count, window_total, window_blue, window_green, window_red,
	// window_white, window_black, one zero pad bit
	output logic [279:0]                  m_tdata
);
	import ccpc_pkg::*;

	localparam int SIDE_W = $clog2(MAX_SIDE + 1);
	localparam int CMP_W = (SIDE_W > CFG_W) ? SIDE_W : CFG_W;
	localparam logic [CMP_W-1:0] SIDE_LIM = CMP_W'(MAX_SIDE);

	logic [CFG_W-1:0] mode_q, left_q, right_q, top_q, bottom_q;

	logic             v_s1, last_s1;
	logic [PIX_W-1:0] blue_s1, green_s1, red_s1, mask_s1;
	logic [POS_W-1:0] col_s1, row_s1;

	class_cnt_t  cls_q, cls_nxt;
	window_cnt_t win_q, win_nxt;

	logic             use_on, blank;
	logic [PIX_W-1:0] b, g, r;
	logic             is_blue, is_green, is_red, is_black, is_gray;
	logic             is_wred, is_white, in_win;
	logic [CMP_W-1:0] lim_l, lim_r, lim_t, lim_b, col_x, row_x;

	logic      snap_ready, fire_s1;
	snapshot_t snap;
	report_t   rep;

	function automatic logic [CMP_W-1:0] clamp_side(input logic [CFG_W-1:0] v);
		logic [CMP_W-1:0] x;
		x = CMP_W'(v);
		return (x > SIDE_LIM) ? SIDE_LIM : x;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0;
			left_q <= '0;
			right_q <= CFG_W'(4096);
			top_q <= '0;
			bottom_q <= CFG_W'(4096);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE: mode_q <= cfg_data;
				REG_LEFT: left_q <= cfg_data;
				REG_RIGHT: right_q <= cfg_data;
				REG_TOP: top_q <= cfg_data;
				REG_BOTTOM: bottom_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign s_tready = !v_s1 || !last_s1 || snap_ready;
	assign fire_s1 = v_s1 && (!last_s1 || snap_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready) begin
			blue_s1 <= s_tdata[7:0];
			green_s1 <= s_tdata[15:8];
			red_s1 <= s_tdata[23:16];
			mask_s1 <= s_tdata[31:24];
			col_s1 <= s_tdata[43:32];
			row_s1 <= s_tdata[55:44];
			last_s1 <= s_tlast;
		end
	end

	assign use_on = mode_q[MF_USE];
	assign blank = mode_q[MF_MASK] && (mask_s1 != PIX_FULL);
	assign b = blank ? PIX_ZERO : blue_s1;
	assign g = blank ? PIX_ZERO : green_s1;
	assign r = blank ? PIX_ZERO : red_s1;

	assign is_blue = (b == PIX_FULL) && (g == PIX_ZERO) && (r == PIX_ZERO);
	assign is_green = (b == PIX_ZERO) && (g == PIX_FULL) && (r == PIX_ZERO);
	assign is_red = !is_blue && !is_green && (b < RED_LIMIT) && (g < RED_LIMIT)
			&& (r == PIX_FULL);
	assign is_black = (b == PIX_ZERO) && (g == PIX_ZERO) && (r == PIX_ZERO);
	assign is_gray = !is_blue && !is_green && !is_red && !is_black;
	assign is_wred = (b == PIX_ZERO) && (g == PIX_ZERO) && (r == PIX_FULL);
	assign is_white = !is_blue && !is_green && !is_wred && (b > WHITE_LIMIT)
			&& (g > WHITE_LIMIT) && (r > WHITE_LIMIT);

	assign lim_l = clamp_side(left_q);
	assign lim_r = clamp_side(right_q);
	assign lim_t = clamp_side(top_q);
	assign lim_b = clamp_side(bottom_q);
	assign col_x = CMP_W'(col_s1);
	assign row_x = CMP_W'(row_s1);
	assign in_win = (col_x >= lim_l) && (col_x < lim_r) && (row_x >= lim_t)
			&& (row_x < lim_b) && !is_black;

	always_comb begin
		cls_nxt.red = sat_inc(cls_q.red, use_on && is_red);
		cls_nxt.green = sat_inc(cls_q.green, use_on && is_green);
		cls_nxt.blue = sat_inc(cls_q.blue, use_on && is_blue);
		cls_nxt.gray = sat_inc(cls_q.gray, use_on && is_gray);
		win_nxt.blue = sat_inc(win_q.blue, use_on && in_win && is_blue);
		win_nxt.green = sat_inc(win_q.green, use_on && in_win && is_green);
		win_nxt.red = sat_inc(win_q.red, use_on && in_win && is_wred);
		win_nxt.white = sat_inc(win_q.white, use_on && in_win && is_white);
		win_nxt.black = sat_inc(win_q.black, use_on && in_win && !is_blue && !is_green
				&& !is_wred && !is_white);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cls_q <= '0;
			win_q <= '0;
		end else if (fire_s1) begin
			if (last_s1) begin
				cls_q <= '0;
				win_q <= '0;
			end else begin
				cls_q <= cls_nxt;
				win_q <= win_nxt;
			end
		end
	end

	assign snap.cls = cls_nxt;
	assign snap.win = win_nxt;

	ccpc_report u_report (
		.clk        (clk),
		.arst_n     (arst_n),
		.mode_flags (mode_q),
		.in_valid   (v_s1 && last_s1),
		.in_ready   (snap_ready),
		.in_snap    (snap),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_report (rep)
	);

	assign m_tdata = {1'b0, rep.win.black, rep.win.white, rep.win.red, rep.win.green,
			rep.win.blue, rep.win_total, rep.cls.gray, rep.cls.blue, rep.cls.green,
			rep.cls.red, rep.total, rep.sel};

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
			(fire_s1 && last_s1) |=> (cls_q == '0) && (win_q == '0))
		else $error("counters not cleared after the last pixel");

	a_stall_only_on_last: assert property (@(posedge clk) disable iff (!arst_n)
			!s_tready |-> (v_s1 && last_s1))
		else $error("input stalled without a waiting last pixel");

	a_auto_onehot: assert property (@(posedge clk) disable iff (!arst_n)
			(m_tvalid && mode_q[MF_USE] && mode_q[MF_AUTO]) |-> $onehot(rep.sel))
		else $error("auto mode picked other than one class");

	a_use_off_zero: assert property (@(posedge clk) disable iff (!arst_n)
			(m_tvalid && !mode_q[MF_USE]) |-> (m_tdata == '0))
		else $error("result not zero with counting off");

endmodule

FILE: hw/rtl/ccpc_report.sv
// ----------------------------------------------------------------------------
// Colour class pixel counter report pipeline
// Takes the final counts of a frame, picks the classes, sums the totals and
// masks the window counts over four elastic stages up to the result register.
// ----------------------------------------------------------------------------
module ccpc_report (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [ccpc_pkg::CFG_W-1:0] mode_flags,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  ccpc_pkg::snapshot_t      in_snap,
	output logic                     out_valid,
	input  logic                     out_ready,
	output ccpc_pkg::report_t        out_report
);
	import ccpc_pkg::*;

	logic v_s2, v_s3, v_s4, v_s5, v_o;
	logic rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_o;

	snapshot_t snap_s2;

	logic [CNT_W-1:0] a_val_s3, b_val_s3, p0_s3, p1_s3;
	logic [SEL_W-1:0] a_sel_s3, b_sel_s3;
	snapshot_t        snap_s3;

	logic [SEL_W-1:0] sel_s4;
	logic [CNT_W-1:0] total_s4;
	class_cnt_t       cls_s4;
	window_cnt_t      win_s4;

	logic [SEL_W-1:0] sel_s5;
	logic [CNT_W-1:0] total_s5, wp0_s5, wp1_s5;
	class_cnt_t       cls_s5;
	window_cnt_t      win_s5;

	report_t rep_q;

	logic [SEL_W-1:0] man_sel;
	logic             use_on;
	logic [SEL_W-1:0] sel_c;
	logic [CNT_W-1:0] total_c;
	window_cnt_t      win_c;
	logic [CNT_W+1:0] wsum_c;

	assign rdy_o = !v_o || out_ready;
	assign rdy_s5 = !v_s5 || rdy_o;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign in_ready = rdy_s2;

	assign man_sel = mode_flags[MF_SEL_LO +: SEL_W];
	assign use_on = mode_flags[MF_USE];

	always_comb begin
		if (mode_flags[MF_AUTO]) begin
			sel_c = (b_val_s3 > a_val_s3) ? b_sel_s3 : a_sel_s3;
			total_c = (b_val_s3 > a_val_s3) ? b_val_s3 : a_val_s3;
		end else begin
			sel_c = man_sel;
			total_c = sat_add(p0_s3, p1_s3);
		end
		if (!use_on) begin
			sel_c = '0;
			total_c = '0;
		end
		win_c.blue = (mode_flags[MF_WBLUE] && !sel_c[2]) ? snap_s3.win.blue : '0;
		win_c.green = (mode_flags[MF_WGREEN] && !sel_c[1]) ? snap_s3.win.green : '0;
		win_c.red = (mode_flags[MF_WRED] && !sel_c[0]) ? snap_s3.win.red : '0;
		win_c.white = (mode_flags[MF_WWHITE] && !sel_c[3]) ? snap_s3.win.white : '0;
		win_c.black = (mode_flags[MF_WBLACK] && !sel_c[3]) ? snap_s3.win.black : '0;
		if (!(use_on && mode_flags[MF_WIN])) begin
			win_c = '0;
		end
	end

	assign wsum_c = {2'b00, wp0_s5} + {2'b00, wp1_s5} + {2'b00, win_s5.black};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_o <= 1'b0;
		end else begin
			if (rdy_s2) v_s2 <= in_valid;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_o) v_o <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			snap_s2 <= in_snap;
		end
		if (rdy_s3) begin
			snap_s3 <= snap_s2;
			if (snap_s2.cls.red > snap_s2.cls.gray) begin
				a_val_s3 <= snap_s2.cls.red;
				a_sel_s3 <= SEL_RED;
			end else begin
				a_val_s3 <= snap_s2.cls.gray;
				a_sel_s3 <= SEL_GRAY;
			end
			if (snap_s2.cls.blue > snap_s2.cls.green) begin
				b_val_s3 <= snap_s2.cls.blue;
				b_sel_s3 <= SEL_BLUE;
			end else begin
				b_val_s3 <= snap_s2.cls.green;
				b_sel_s3 <= SEL_GREEN;
			end
			p0_s3 <= sat_add(man_sel[0] ? snap_s2.cls.red : '0,
					man_sel[1] ? snap_s2.cls.green : '0);
			p1_s3 <= sat_add(man_sel[2] ? snap_s2.cls.blue : '0,
					man_sel[3] ? snap_s2.cls.gray : '0);
		end
		if (rdy_s4) begin
			sel_s4 <= sel_c;
			total_s4 <= total_c;
			cls_s4 <= use_on ? snap_s3.cls : '0;
			win_s4 <= win_c;
		end
		if (rdy_s5) begin
			sel_s5 <= sel_s4;
			total_s5 <= total_s4;
			cls_s5 <= cls_s4;
			win_s5 <= win_s4;
			wp0_s5 <= sat_add(win_s4.blue, win_s4.green);
			wp1_s5 <= sat_add(win_s4.red, win_s4.white);
		end
		if (rdy_o) begin
			rep_q.sel <= sel_s5;
			rep_q.total <= total_s5;
			rep_q.cls <= cls_s5;
			rep_q.win <= win_s5;
			rep_q.win_total <= (wsum_c > {2'b00, CNT_MAX}) ? CNT_MAX : wsum_c[CNT_W-1:0];
		end
	end

	assign out_valid = v_o;
	assign out_report = rep_q;

endmodule
